FILE: hw/rtl/ttpc_pkg.sv
// Shared types and constants of the torus two-point correlator.
`default_nettype none

package ttpc_pkg;

    localparam int ACTION_W  = 2;
    localparam int SITE_W    = 12;
    localparam int SAMPLE_W  = 16;
    localparam int BIN_SEL_W = 11;
    localparam int SUM_W     = 64;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT  = 1'b1;

    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ACCUM = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic                         site_ok;
        logic                         bin_ok;
        logic [SITE_W-1:0]            site;
        logic signed [SAMPLE_W-1:0]   sample;
        logic signed [SAMPLE_W-1:0]   mean;
        logic [BIN_SEL_W-1:0]         bin_select;
    } t_cmd;

    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_qhead;

endpackage

`default_nettype wire

FILE: hw/rtl/ttpc_in_if.sv
// Input channel interface carrying command transactions.
`default_nettype none

interface ttpc_in_if;
    import ttpc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic [SITE_W-1:0]           site;
    logic signed [SAMPLE_W-1:0]  sample;
    logic signed [SAMPLE_W-1:0]  mean;
    logic [BIN_SEL_W-1:0]        bin_select;

    modport source (output valid, action, site, sample, mean, bin_select, input ready);
    modport sink   (input valid, action, site, sample, mean, bin_select, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ttpc_out_if.sv
// Output channel interface carrying result transactions.
`default_nettype none

interface ttpc_out_if;
    import ttpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [BIN_SEL_W-1:0]     bin_index;
    logic signed [SUM_W-1:0]  meas_sum;
    logic signed [SUM_W-1:0]  run_sum;

    modport source (output valid, kind, bin_index, meas_sum, run_sum, input ready);
    modport sink   (input valid, kind, bin_index, meas_sum, run_sum, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ttpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttpc_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

FILE: hw/rtl/ttpc_front.sv
// Front end: accepts and classifies command transactions into a two-entry queue.
`default_nettype none

module ttpc_front #(
    parameter int MAX_SPACE = 64,
    parameter int MAX_TIME  = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ttpc_in_if.sink         i_in,
    input  wire logic       i_hold,
    input  wire logic       i_pop,
    output ttpc_pkg::t_qhead o_head
);
    import ttpc_pkg::*;

    localparam int SITE_COUNT = MAX_SPACE * MAX_TIME;
    localparam int BIN_COUNT  = (MAX_SPACE / 2 + 1) * (MAX_TIME / 2 + 1);
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int CW         = $clog2(QDEPTH + 1);

    t_cmd           cmd;
    logic           push;
    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [CW-1:0]  r_count;

    assign i_in.ready = !i_hold && (r_count < CW'(QDEPTH));
    assign push       = i_in.valid && i_in.ready;

    always_comb begin
        case (i_in.action)
            OP_LOAD:  cmd.op = OP_LOAD;
            OP_ACCUM: cmd.op = OP_ACCUM;
            OP_READ:  cmd.op = OP_READ;
            default:  cmd.op = OP_CLEAR;
        endcase
        // Out-of-range loads are dropped and out-of-range reads return zero sums.
        cmd.site_ok    = 32'(i_in.site) < 32'(SITE_COUNT);
        cmd.bin_ok     = 32'(i_in.bin_select) < 32'(BIN_COUNT);
        cmd.site       = i_in.site;
        cmd.sample     = i_in.sample;
        cmd.mean       = i_in.mean;
        cmd.bin_select = i_in.bin_select;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

    assign o_head.vld = (r_count != '0);
    assign o_head.cmd = r_q[r_rptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QDEPTH))
        else $error("queue count exceeds depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.vld)
        else $error("pop from empty queue");
endmodule

`default_nettype wire

FILE: hw/rtl/ttpc_back.sv
// Back end: site store, bin stores, pair-walk pipeline and result register.
`default_nettype none

module ttpc_back #(
    parameter int MAX_SPACE = 64,
    parameter int MAX_TIME  = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [ttpc_pkg::CFG_W-1:0] i_circ,
    input  wire logic [ttpc_pkg::CFG_W-1:0] i_text,
    input  ttpc_pkg::t_qhead                i_head,
    output logic                            o_pop,
    output logic                            o_init,
    ttpc_out_if.source                      o_out
);
    import ttpc_pkg::*;

    localparam int SITE_COUNT = MAX_SPACE * MAX_TIME;
    localparam int BIN_COUNT  = (MAX_SPACE / 2 + 1) * (MAX_TIME / 2 + 1);
    localparam int SAW        = $clog2(SITE_COUNT);
    localparam int BW         = $clog2(BIN_COUNT);
    localparam int XW         = $clog2(MAX_SPACE + 1);
    localparam int TW         = $clog2(MAX_TIME + 1);
    localparam int DW         = (XW > TW) ? XW : TW;
    localparam int PW         = XW + TW;
    localparam int VW         = 2 * SAMPLE_W + 1;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MCLR  = 8'b0000_0100,
        S_ROW   = 8'b0000_1000,
        S_PAIR  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_RCLR  = 8'b0100_0000,
        S_READ  = 8'b1000_0000
    } t_state;

    function automatic logic [DW-1:0] wrap_dist(input logic [DW-1:0] a,
                                                input logic [DW-1:0] b,
                                                input logic [DW-1:0] len);
        logic [DW-1:0] d;
        d = (a > b) ? a - b : b - a;
        return (d > (len >> 1)) ? len - d : d;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VW-1:0]    b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W + 1 - VW){b[VW-1]}}, b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [31:0]   circ32, text32;
    logic [XW-1:0] s1, xlen;
    logic [TW-1:0] lt;

    logic [BW-1:0]  r_cnt;
    logic [XW-1:0]  r_xi, r_xj;
    logic [TW-1:0]  r_ti, r_tj;
    logic [SAW-1:0] r_ii, r_jj;

    logic sweep, sweep_last, last_xj, last_j, last_xi, last_i;
    logic pipe_empty, out_free, result_fire;

    logic signed [2*SAMPLE_W-1:0] r_msq;
    logic signed [SAMPLE_W-1:0]   r_pi;

    logic          r_p1_vld, r_p1_row;
    logic [XW-1:0] r_p1_dx;
    logic [TW-1:0] r_p1_dt;
    logic [PW-1:0] idx_wide;

    logic                         r_p2_vld;
    logic [BW-1:0]                r_p2_idx;
    logic signed [2*SAMPLE_W-1:0] r_p2_prod;

    logic                 r_p3_vld;
    logic [BW-1:0]        r_p3_idx;
    logic [VW-1:0]        r_p3_val;

    logic                 r_fw_vld;
    logic [BW-1:0]        r_fw_idx;
    logic [SUM_W-1:0]     r_fw_meas, r_fw_run;
    logic [SUM_W-1:0]     meas_cur, run_cur, n_meas, n_run;

    logic                 r_rd_ok;
    logic [BIN_SEL_W-1:0] r_rd_bsel;

    logic                 r_out_vld;
    logic                 r_out_kind;
    logic [BIN_SEL_W-1:0] r_out_bin;
    logic [SUM_W-1:0]     r_out_meas, r_out_run;

    logic                 samp_we, samp_re;
    logic [SAW-1:0]       samp_raddr;
    logic [SAMPLE_W-1:0]  samp_rdata;

    logic                 bin_re, rd_issue;
    logic [BW-1:0]        bin_raddr, bin_waddr;
    logic                 meas_we, run_we;
    logic [SUM_W-1:0]     meas_wdata, run_wdata, meas_rdata, run_rdata;

    // Registers outside their range are saturated into [2, MAX].
    always_comb begin
        circ32 = 32'(i_circ);
        text32 = 32'(i_text);
        if (circ32 < 32'd2) begin
            s1 = XW'(2);
        end else if (circ32 > 32'(MAX_SPACE)) begin
            s1 = XW'(MAX_SPACE);
        end else begin
            s1 = XW'(circ32);
        end
        if (text32 < 32'd2) begin
            lt = TW'(2);
        end else if (text32 > 32'(MAX_TIME)) begin
            lt = TW'(MAX_TIME);
        end else begin
            lt = TW'(text32);
        end
        xlen = (s1 >> 1) + 1'b1;
    end

    assign sweep      = (r_state == S_INIT) || (r_state == S_MCLR) || (r_state == S_RCLR);
    assign sweep_last = (r_cnt == BW'(BIN_COUNT - 1));
    assign last_xj    = (r_xj == s1 - 1'b1);
    assign last_j     = last_xj && (r_tj == lt - 1'b1);
    assign last_xi    = (r_xi == s1 - 1'b1);
    assign last_i     = last_xi && (r_ti == lt - 1'b1);
    assign pipe_empty = !r_p1_vld && !r_p2_vld && !r_p3_vld;
    assign out_free   = !r_out_vld || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && i_head.vld;
    assign o_init     = (r_state == S_INIT);
    assign rd_issue   = o_pop && (i_head.cmd.op == OP_READ) && i_head.cmd.bin_ok;
    assign result_fire = ((r_state == S_DRAIN) && pipe_empty && out_free)
                       || ((r_state == S_READ) && out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_head.vld) begin
                    case (i_head.cmd.op)
                        OP_ACCUM: n_state = S_MCLR;
                        OP_READ:  n_state = S_READ;
                        OP_CLEAR: n_state = S_RCLR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MCLR: begin
                if (sweep_last) n_state = S_ROW;
            end
            S_ROW:  n_state = S_PAIR;
            S_PAIR: begin
                if (last_j) n_state = last_i ? S_DRAIN : S_ROW;
            end
            S_DRAIN: begin
                if (pipe_empty && out_free) n_state = S_IDLE;
            end
            S_RCLR: begin
                if (sweep_last) n_state = S_IDLE;
            end
            S_READ: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: clearing sweeps and the i/j site walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_xi    <= '0;
            r_ti    <= '0;
            r_ii    <= '0;
            r_xj    <= '0;
            r_tj    <= '0;
            r_jj    <= '0;
        end else begin
            r_state <= n_state;
            if (sweep) begin
                r_cnt <= sweep_last ? '0 : r_cnt + 1'b1;
            end
            if (r_state == S_MCLR && sweep_last) begin
                r_xi <= '0;
                r_ti <= '0;
                r_ii <= '0;
            end
            if (r_state == S_ROW) begin
                r_xj <= '0;
                r_tj <= '0;
                r_jj <= '0;
            end
            if (r_state == S_PAIR) begin
                r_jj <= r_jj + 1'b1;
                if (last_xj) begin
                    r_xj <= '0;
                    r_tj <= r_tj + 1'b1;
                end else begin
                    r_xj <= r_xj + 1'b1;
                end
                if (last_j) begin
                    r_ii <= r_ii + 1'b1;
                    if (last_xi) begin
                        r_xi <= '0;
                        r_ti <= r_ti + 1'b1;
                    end else begin
                        r_xi <= r_xi + 1'b1;
                    end
                end
            end
        end
    end

    assign idx_wide = PW'(r_p1_dx) + PW'(xlen) * PW'(r_p1_dt);

    // Pair pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_p1_vld <= (r_state == S_ROW) || (r_state == S_PAIR);
            r_p2_vld <= r_p1_vld && !r_p1_row;
            r_p3_vld <= r_p2_vld;
            r_fw_vld <= r_p3_vld;
        end
    end

    // Pipeline payload: distances, bin index and product, then read-modify-write.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd.op == OP_ACCUM) begin
            r_msq <= i_head.cmd.mean * i_head.cmd.mean;
        end
        r_p1_row <= (r_state == S_ROW);
        r_p1_dx  <= XW'(wrap_dist(DW'(r_xj), DW'(r_xi), DW'(s1)));
        r_p1_dt  <= TW'(wrap_dist(DW'(r_tj), DW'(r_ti), DW'(lt)));
        if (r_p1_vld && r_p1_row) begin
            r_pi <= $signed(samp_rdata);
        end
        r_p2_idx  <= BW'(idx_wide);
        r_p2_prod <= r_pi * $signed(samp_rdata);
        r_p3_idx  <= r_p2_idx;
        r_p3_val  <= {r_p2_prod[2*SAMPLE_W-1], r_p2_prod} - {r_msq[2*SAMPLE_W-1], r_msq};
        r_fw_idx  <= r_p3_idx;
        r_fw_meas <= n_meas;
        r_fw_run  <= n_run;
        if (rd_issue || (o_pop && i_head.cmd.op == OP_READ)) begin
            r_rd_ok   <= i_head.cmd.bin_ok;
            r_rd_bsel <= i_head.cmd.bin_select;
        end
    end

    // The RAM returns old data when the previous cycle wrote the same bin.
    always_comb begin
        if (r_fw_vld && r_fw_idx == r_p3_idx) begin
            meas_cur = r_fw_meas;
            run_cur  = r_fw_run;
        end else begin
            meas_cur = meas_rdata;
            run_cur  = run_rdata;
        end
        n_meas = sat_add(meas_cur, r_p3_val);
        n_run  = sat_add(run_cur, r_p3_val);
    end

    assign samp_we    = o_pop && (i_head.cmd.op == OP_LOAD) && i_head.cmd.site_ok;
    assign samp_re    = (r_state == S_ROW) || (r_state == S_PAIR);
    assign samp_raddr = (r_state == S_ROW) ? r_ii : r_jj;

    assign bin_re     = r_p2_vld || rd_issue;
    assign bin_raddr  = rd_issue ? BW'(i_head.cmd.bin_select) : r_p2_idx;
    assign bin_waddr  = r_p3_vld ? r_p3_idx : r_cnt;
    assign meas_we    = r_p3_vld || (r_state == S_INIT) || (r_state == S_MCLR);
    assign run_we     = r_p3_vld || (r_state == S_INIT) || (r_state == S_RCLR);
    assign meas_wdata = r_p3_vld ? n_meas : '0;
    assign run_wdata  = r_p3_vld ? n_run : '0;

    ttpc_ram #(.WIDTH(SAMPLE_W), .DEPTH(SITE_COUNT)) u_samples (
        .i_clk   (i_clk),
        .i_we    (samp_we),
        .i_waddr (SAW'(i_head.cmd.site)),
        .i_wdata (i_head.cmd.sample),
        .i_re    (samp_re),
        .i_raddr (samp_raddr),
        .o_rdata (samp_rdata)
    );

    ttpc_ram #(.WIDTH(SUM_W), .DEPTH(BIN_COUNT)) u_meas_bins (
        .i_clk   (i_clk),
        .i_we    (meas_we),
        .i_waddr (bin_waddr),
        .i_wdata (meas_wdata),
        .i_re    (bin_re),
        .i_raddr (bin_raddr),
        .o_rdata (meas_rdata)
    );

    ttpc_ram #(.WIDTH(SUM_W), .DEPTH(BIN_COUNT)) u_run_bins (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (bin_waddr),
        .i_wdata (run_wdata),
        .i_re    (bin_re),
        .i_raddr (bin_raddr),
        .o_rdata (run_rdata)
    );

    // Output register decouples the result from the downstream ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (result_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_fire) begin
            if (r_state == S_READ) begin
                r_out_kind <= KIND_READ;
                r_out_bin  <= r_rd_bsel;
                r_out_meas <= r_rd_ok ? meas_rdata : '0;
                r_out_run  <= r_rd_ok ? run_rdata : '0;
            end else begin
                r_out_kind <= KIND_ACCUM;
                r_out_bin  <= '0;
                r_out_meas <= '0;
                r_out_run  <= '0;
            end
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.kind      = r_out_kind;
    assign o_out.bin_index = r_out_bin;
    assign o_out.meas_sum  = r_out_meas;
    assign o_out.run_sum   = r_out_run;

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_p3_vld && sweep))
        else $error("pipeline write during a clearing sweep");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> pipe_empty)
        else $error("pair pipeline busy while idle");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> (32'(r_p2_idx) < 32'(BIN_COUNT)))
        else $error("bin index out of range");
endmodule

`default_nettype wire

FILE: hw/rtl/torus_two_point_correlator_core.sv
// Top level of the torus two-point correlator: configuration registers, front and back end.
// Usage:
//   i_in carries commands (load sample, accumulate, read bin, clear running bins), one
//   transaction per valid/ready handshake. o_out carries results: one transaction when an
//   accumulate finishes and one for each bin read. Loads and clears give no result.
//   Configuration (circumference, time extent) is written through i_cfg_we/i_cfg_index/
//   i_cfg_data while the block is idle; out-of-range values saturate into [2, MAX].
// Timing:
//   A two-entry command queue sits in front of a sequencer that runs one command at a time.
//   A load writes the sample store as it leaves the queue, a read fetches both bin RAMs
//   into the output register, and a clear sweeps every running bin to zero. Accumulate
//   sweeps every measurement bin to zero, then walks all pairs of the V = circumference *
//   time_extent sites, one site pair per cycle through the read-modify-write pipeline on
//   the bin RAMs, with a row step before each row to fetch its sample.
// Reset and stalls:
//   After reset both bin stores, BIN_COUNT bins each (1089 at the defaults), are swept
//   to zero with i_in.ready low. Results wait in an output register while o_out.ready
//   is low; the queue keeps taking commands until it fills, then i_in.ready drops.
`default_nettype none

module torus_two_point_correlator_core #(
    parameter int MAX_SPACE = 64,
    parameter int MAX_TIME  = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ttpc_in_if.sink                             i_in,
    ttpc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [ttpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ttpc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ttpc_pkg::*;

    logic [CFG_W-1:0] r_circ;
    logic [CFG_W-1:0] r_text;
    t_qhead           head;
    logic             pop;
    logic             init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ <= CFG_RESET;
            r_text <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CIRC: r_circ <= i_cfg_data;
                CFG_TEXT: r_text <= i_cfg_data;
                default:  r_circ <= r_circ;
            endcase
        end
    end

    ttpc_front #(.MAX_SPACE(MAX_SPACE), .MAX_TIME(MAX_TIME)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_hold  (init),
        .i_pop   (pop),
        .o_head  (head)
    );

    ttpc_back #(.MAX_SPACE(MAX_SPACE), .MAX_TIME(MAX_TIME)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_circ  (r_circ),
        .i_text  (r_text),
        .i_head  (head),
        .o_pop   (pop),
        .o_init  (init),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire
